[rtl/aafl_pkg.sv]
// shared types and constants for the arena allocator
`default_nettype none
package aafl_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int ARENA_BYTES_W = 24;
  localparam int LIST_CAP_W = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int ALIGN_BITS = 3;
  localparam int ENTRY_BYTES_SHIFT = 4;

  localparam logic REG_ARENA_BYTES = 1'b0;
  localparam logic REG_LIST_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_FRONT    = 3'd1,
    OP_BACK     = 3'd2,
    OP_ROLLBACK = 3'd3,
    OP_REWIND   = 3'd4,
    OP_RESET    = 3'd5,
    OP_RELEASE  = 3'd6,
    OP_GET      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_APPLY,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_OPEN,
    CELL_CLOSE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       wr_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/aafl_if.sv]
// request and response channel interfaces
`default_nettype none
interface aafl_req_if import aafl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [OFFSET_BITS-1:0] length;
  logic [OFFSET_BITS-1:0] address;
  modport source (output valid, operation, length, address, input ready);
  modport sink (input valid, operation, length, address, output ready);
endinterface

interface aafl_rsp_if import aafl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_W = $clog2(MAX_ENTRIES_DEF + 1)
);
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [OFFSET_BITS-1:0] block_offset;
  logic [COUNT_W-1:0]     free_entries;
  modport source (output valid, ok, block_offset, free_entries, input ready);
  modport sink (input valid, ok, block_offset, free_entries, output ready);
endinterface
`default_nettype wire

[rtl/aafl_cell.sv]
// one free list entry cell of the shifting chain
`default_nettype none
module aafl_cell import aafl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int IDX_W = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                   clk,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [IDX_W-1:0]       pos_idx,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire logic [OFFSET_BITS-1:0] wr_start,
  input  wire logic [OFFSET_BITS-1:0] wr_len,
  input  wire logic [OFFSET_BITS-1:0] left_start,
  input  wire logic [OFFSET_BITS-1:0] left_len,
  input  wire logic [OFFSET_BITS-1:0] right_start,
  input  wire logic [OFFSET_BITS-1:0] right_len,
  output logic      [OFFSET_BITS-1:0] start,
  output logic      [OFFSET_BITS-1:0] len
);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [OFFSET_BITS-1:0] start_next;
  logic [OFFSET_BITS-1:0] len_next;

  always_comb begin
    start_next = start;
    len_next = len;
    unique case (ctrl.mode)
      CELL_ROTATE: begin
        start_next = right_start;
        len_next = right_len;
      end
      CELL_OPEN: begin
        if (MY_IDX > pos_idx) begin
          start_next = left_start;
          len_next = left_len;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= pos_idx) begin
          start_next = right_start;
          len_next = right_len;
        end
      end
      default: begin
      end
    endcase
    if (ctrl.wr_en && MY_IDX == wr_idx) begin
      start_next = wr_start;
      len_next = wr_len;
    end
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len <= len_next;
  end
endmodule
`default_nettype wire

[rtl/aafl_chain.sv]
// row of free list cells, head cell visible to the controller
`default_nettype none
module aafl_chain import aafl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int IDX_W = 6
) (
  input  wire logic                   clk,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [IDX_W-1:0]       pos_idx,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire logic [OFFSET_BITS-1:0] wr_start,
  input  wire logic [OFFSET_BITS-1:0] wr_len,
  output logic      [OFFSET_BITS-1:0] head_start,
  output logic      [OFFSET_BITS-1:0] head_len
);
  logic [OFFSET_BITS-1:0] starts [MAX_ENTRIES];
  logic [OFFSET_BITS-1:0] lens [MAX_ENTRIES];

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    localparam int LEFT = (k == 0) ? 0 : k - 1;
    localparam int RIGHT = (k + 1) % MAX_ENTRIES;
    aafl_cell #(
      .OFFSET_BITS(OFFSET_BITS),
      .IDX_W(IDX_W),
      .CELL_IDX(k)
    ) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .pos_idx(pos_idx),
      .wr_idx(wr_idx),
      .wr_start(wr_start),
      .wr_len(wr_len),
      .left_start(starts[LEFT]),
      .left_len(lens[LEFT]),
      .right_start(starts[RIGHT]),
      .right_len(lens[RIGHT]),
      .start(starts[k]),
      .len(lens[k])
    );
  end

  assign head_start = starts[0];
  assign head_len = lens[0];
endmodule
`default_nettype wire

[rtl/arena_allocator_with_free_list.sv]
// arena allocator top level: request sequencer, registers and free list chain
// Each request takes one word in and gives one word out. Init, front and back
// allocation, rollback, rewind and reset pass from the accept through an
// execute state to a result state that loads the output register. Release and
// get pass instead through a scan state, an apply state and the result state:
// the free list lives in a row of cells that rotates once past the head cell
// to find the place, then the apply state shifts or rewrites entries in
// parallel. A new request is taken as soon as the previous result has been
// placed in the output register, so a stalled output holds off the next
// request.
`default_nettype none
module arena_allocator_with_free_list import aafl_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  aafl_req_if.sink                   req,
  aafl_rsp_if.source                 rsp
);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int OB = OFFSET_BITS;
  localparam int CAPX_W = CNT_W + ENTRY_BYTES_SHIFT;
  localparam int CMP_W = OB + CAPX_W;

  logic [ARENA_BYTES_W-1:0] arena_bytes;
  logic [LIST_CAP_W-1:0]    list_capacity;

  state_t state, state_next;

  logic          arena_live;
  logic          list_active;
  logic [OB-1:0] bump_offset;
  logic [OB-1:0] previous_offset;
  logic [OB-1:0] usable_top;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] cap_latched;

  op_t           op_q;
  logic [OB-1:0] len_q;
  logic [OB-1:0] addr_q;

  logic [CNT_W-1:0] scan_cnt;
  logic          have_prev;
  logic [OB-1:0] prev_s;
  logic [OB-1:0] prev_l;
  logic          found;
  logic [CNT_W-1:0] i_idx;
  logic [OB-1:0] nxt_s;
  logic [OB-1:0] nxt_l;
  logic          exact_found;
  logic [CNT_W-1:0] exact_idx;
  logic [OB-1:0] exact_s;
  logic          cand_found;
  logic [CNT_W-1:0] cand_idx;
  logic [OB-1:0] cand_s;
  logic [OB-1:0] cand_l;

  logic          res_ok;
  logic [OB-1:0] res_blk;
  logic          out_valid;
  logic          out_ok;
  logic [OB-1:0] out_blk;
  logic [CNT_W-1:0] out_cnt;

  cell_ctrl_t    ctrl;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [OB-1:0] wr_start;
  logic [OB-1:0] wr_len;
  logic [OB-1:0] head_start;
  logic [OB-1:0] head_len;

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_ARENA_BYTES:   prdata = APB_DATA_W'(arena_bytes);
      REG_LIST_CAPACITY: prdata = APB_DATA_W'(list_capacity);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes <= '0;
      list_capacity <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ARENA_BYTES:   arena_bytes <= pwdata[ARENA_BYTES_W-1:0];
        REG_LIST_CAPACITY: list_capacity <= pwdata[LIST_CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // arithmetic
  logic [OB:0]      al;
  logic             len_zero;
  logic [OB-1:0]    top0;
  logic [CNT_W-1:0] cap_sat;
  logic [CAPX_W-1:0] cap_bytes;
  logic             cap_fits;
  logic [OB:0]      room;
  logic             in_scan;

  assign al = ({1'b0, len_q} + (OB+1)'(7)) & ~(OB+1)'(7);
  assign len_zero = (len_q == '0);
  assign top0 = OB'({{OB{1'b0}}, arena_bytes[ARENA_BYTES_W-1:ALIGN_BITS],
                     {ALIGN_BITS{1'b0}}});
  assign cap_sat = (32'(list_capacity) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                           : CNT_W'(list_capacity);
  assign cap_bytes = {cap_sat, {ENTRY_BYTES_SHIFT{1'b0}}};
  assign cap_fits = (CMP_W'(cap_bytes) <= CMP_W'(top0));
  assign room = {1'b0, usable_top - bump_offset};
  assign in_scan = (req.operation == OP_RELEASE || req.operation == OP_GET) &&
                   arena_live && list_active && (req.length != '0);

  // release and get decisions after the scan
  logic [OB:0] rel_end;
  logic [OB:0] prev_end;
  logic        rel_bad;
  logic        overlap;
  logic        left;
  logic        right;
  logic        full;
  logic        rel_ok;
  logic        get_ok;
  logic [CNT_W-1:0] i_prev;

  always_comb begin
    rel_end = {1'b0, addr_q} + al;
    prev_end = {1'b0, prev_s} + {1'b0, prev_l};
    rel_bad = (addr_q > bump_offset) || (addr_q[ALIGN_BITS-1:0] != '0) ||
              (al > {1'b0, bump_offset - addr_q});
    overlap = (have_prev && prev_end > {1'b0, addr_q}) ||
              (found && rel_end > {1'b0, nxt_s});
    left = have_prev && prev_end == {1'b0, addr_q};
    right = found && rel_end == {1'b0, nxt_s};
    full = !left && !right && entry_count >= cap_latched;
    rel_ok = !rel_bad && !overlap && !full;
    get_ok = exact_found || cand_found;
    i_prev = i_idx - CNT_W'(1);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req.valid) state_next = in_scan ? ST_SCAN : ST_EXEC;
      ST_EXEC:   state_next = ST_RESULT;
      ST_SCAN:   if (scan_cnt == CNT_W'(MAX_ENTRIES - 1)) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    ctrl.mode = CELL_HOLD;
    ctrl.wr_en = 1'b0;
    pos_idx = '0;
    wr_idx = '0;
    wr_start = '0;
    wr_len = '0;
    unique case (state)
      ST_SCAN: ctrl.mode = CELL_ROTATE;
      ST_APPLY: begin
        if (op_q == OP_RELEASE) begin
          if (rel_ok) begin
            priority if (left && right) begin
              ctrl.mode = CELL_CLOSE;
              pos_idx = i_idx[IDX_W-1:0];
              ctrl.wr_en = 1'b1;
              wr_idx = i_prev[IDX_W-1:0];
              wr_start = prev_s;
              wr_len = prev_l + OB'(al) + nxt_l;
            end else if (left) begin
              ctrl.wr_en = 1'b1;
              wr_idx = i_prev[IDX_W-1:0];
              wr_start = prev_s;
              wr_len = prev_l + OB'(al);
            end else if (right) begin
              ctrl.wr_en = 1'b1;
              wr_idx = i_idx[IDX_W-1:0];
              wr_start = addr_q;
              wr_len = nxt_l + OB'(al);
            end else begin
              ctrl.mode = CELL_OPEN;
              pos_idx = i_idx[IDX_W-1:0];
              ctrl.wr_en = 1'b1;
              wr_idx = i_idx[IDX_W-1:0];
              wr_start = addr_q;
              wr_len = OB'(al);
            end
          end
        end else begin
          priority if (exact_found) begin
            ctrl.mode = CELL_CLOSE;
            pos_idx = exact_idx[IDX_W-1:0];
          end else if (cand_found) begin
            ctrl.wr_en = 1'b1;
            wr_idx = cand_idx[IDX_W-1:0];
            wr_start = cand_s + OB'(al);
            wr_len = cand_l - OB'(al);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      arena_live <= 1'b0;
      list_active <= 1'b0;
      bump_offset <= '0;
      previous_offset <= '0;
      usable_top <= '0;
      entry_count <= '0;
      cap_latched <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready && state != ST_RESULT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_q <= req.operation;
            len_q <= req.length;
            addr_q <= req.address;
            scan_cnt <= '0;
            have_prev <= 1'b0;
            found <= 1'b0;
            i_idx <= '0;
            exact_found <= 1'b0;
            cand_found <= 1'b0;
          end
        end
        ST_EXEC: begin
          res_ok <= 1'b0;
          res_blk <= '0;
          unique case (op_q)
            OP_INIT: begin
              if (arena_bytes != '0) begin
                arena_live <= 1'b1;
                list_active <= 1'b0;
                bump_offset <= '0;
                previous_offset <= '0;
                entry_count <= '0;
                cap_latched <= '0;
                usable_top <= top0;
                if (cap_sat != '0 && cap_fits) begin
                  usable_top <= top0 - OB'(cap_bytes);
                  cap_latched <= cap_sat;
                  list_active <= 1'b1;
                end
                res_ok <= 1'b1;
              end
            end
            OP_FRONT: begin
              if (arena_live && !len_zero && al <= room) begin
                previous_offset <= bump_offset;
                bump_offset <= bump_offset + OB'(al);
                res_blk <= bump_offset;
                res_ok <= 1'b1;
              end
            end
            OP_BACK: begin
              if (arena_live && !len_zero && al <= room) begin
                usable_top <= usable_top - OB'(al);
                res_blk <= usable_top - OB'(al);
                res_ok <= 1'b1;
              end
            end
            OP_ROLLBACK: begin
              if (arena_live && !list_active && previous_offset != bump_offset) begin
                bump_offset <= previous_offset;
                res_ok <= 1'b1;
              end
            end
            OP_REWIND: begin
              if (arena_live && !list_active && !len_zero && al <= {1'b0, bump_offset}) begin
                bump_offset <= bump_offset - OB'(al);
                previous_offset <= bump_offset - OB'(al);
                res_ok <= 1'b1;
              end
            end
            OP_RESET: begin
              if (arena_live) begin
                bump_offset <= '0;
                previous_offset <= '0;
                entry_count <= '0;
                res_ok <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + CNT_W'(1);
          if (scan_cnt < entry_count) begin
            if (!found) begin
              if (head_start < addr_q) begin
                have_prev <= 1'b1;
                prev_s <= head_start;
                prev_l <= head_len;
                i_idx <= scan_cnt + CNT_W'(1);
              end else begin
                found <= 1'b1;
                nxt_s <= head_start;
                nxt_l <= head_len;
              end
            end
            if (!exact_found) begin
              if ({1'b0, head_len} == al) begin
                exact_found <= 1'b1;
                exact_idx <= scan_cnt;
                exact_s <= head_start;
              end else if ({1'b0, head_len} > al && !cand_found) begin
                cand_found <= 1'b1;
                cand_idx <= scan_cnt;
                cand_s <= head_start;
                cand_l <= head_len;
              end
            end
          end
        end
        ST_APPLY: begin
          res_blk <= '0;
          if (op_q == OP_RELEASE) begin
            res_ok <= rel_ok;
            if (rel_ok) begin
              if (left && right) entry_count <= entry_count - CNT_W'(1);
              else if (!left && !right) entry_count <= entry_count + CNT_W'(1);
            end
          end else begin
            res_ok <= get_ok;
            if (exact_found) begin
              res_blk <= exact_s;
              entry_count <= entry_count - CNT_W'(1);
            end else if (cand_found) begin
              res_blk <= cand_s;
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ok <= res_ok;
            out_blk <= res_ok ? res_blk : '0;
            out_cnt <= entry_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.ok = out_ok;
  assign rsp.block_offset = out_blk;
  assign rsp.free_entries = out_cnt;

  aafl_chain #(
    .OFFSET_BITS(OB),
    .MAX_ENTRIES(MAX_ENTRIES),
    .IDX_W(IDX_W)
  ) u_chain (
    .clk(clk),
    .ctrl(ctrl),
    .pos_idx(pos_idx),
    .wr_idx(wr_idx),
    .wr_start(wr_start),
    .wr_len(wr_len),
    .head_start(head_start),
    .head_len(head_len)
  );

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cap_latched) else $error("free list above capacity");
  a_top_bump: assert property (@(posedge clk) disable iff (rst)
    bump_offset <= usable_top) else $error("bump above top");
  a_prev_bump: assert property (@(posedge clk) disable iff (rst)
    previous_offset <= bump_offset) else $error("previous offset above bump");
  a_no_list: assert property (@(posedge clk) disable iff (rst)
    !list_active |-> entry_count == '0) else $error("entries without list");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_cnt == CNT_W'(MAX_ENTRIES - 1)) |=> state == ST_APPLY)
    else $error("scan did not finish");
endmodule
`default_nettype wire
